FILE: hdl/pctc_pkg.sv
// ----------------------------------------------------------------------------
// pctc_pkg: percent codec shared types and constants
// Payload words, decoder state, mode codes and character helpers.
// ----------------------------------------------------------------------------
package pctc_pkg;

  localparam int unsigned CfgDataW = 64;
  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned MaxRes   = 3;

  localparam logic [CfgIdxW-1:0] REG_MODE    = 2'd0;
  localparam logic [CfgIdxW-1:0] REG_MASK_LO = 2'd1;
  localparam logic [CfgIdxW-1:0] REG_MASK_HI = 2'd2;

  localparam logic [1:0] MODE_ENC   = 2'd0;
  localparam logic [1:0] MODE_DEC   = 2'd1;
  localparam int unsigned MODE_KEEP_BIT = 1;

  localparam logic [7:0] CH_PCT   = 8'h25;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_DEL   = 8'h7F;

  typedef enum logic [1:0] {
    PH_IDLE = 2'd0,
    PH_PCT  = 2'd1,
    PH_HEX1 = 2'd2
  } phase_e;

  typedef struct packed {
    phase_e     phase;
    logic [7:0] first_hex;
    logic       err;
  } dec_state_t;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       final_byte;
  } in_word_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       has_byte;
    logic       end_of_string;
    logic       bad_input;
  } out_word_t;

  // {valid, value}
  function automatic logic [4:0] hex_val(input logic [7:0] c);
    logic [4:0] r;
    r = 5'd0;
    if (c >= 8'h30 && c <= 8'h39) begin
      r = {1'b1, 4'(c - 8'h30)};
    end else if (c >= 8'h41 && c <= 8'h46) begin
      r = {1'b1, 4'(c - 8'h37)};
    end else if (c >= 8'h61 && c <= 8'h66) begin
      r = {1'b1, 4'(c - 8'h57)};
    end
    return r;
  endfunction

  function automatic logic [7:0] hex_digit(input logic [3:0] v);
    logic [7:0] r;
    if (v < 4'd10) begin
      r = 8'h30 + {4'd0, v};
    end else begin
      r = 8'h37 + {4'd0, v};
    end
    return r;
  endfunction

  // RFC 3986 gen-delims and sub-delims
  function automatic logic is_uri_delim(input logic [7:0] c);
    logic r;
    case (c)
      8'h3A, 8'h2F, 8'h3F, 8'h23, 8'h5B, 8'h5D, 8'h40,
      8'h21, 8'h24, 8'h26, 8'h27, 8'h28, 8'h29,
      8'h2A, 8'h2B, 8'h2C, 8'h3B, 8'h3D: r = 1'b1;
      default:                            r = 1'b0;
    endcase
    return r;
  endfunction

endpackage

FILE: hdl/pctc_in_if.sv
// ----------------------------------------------------------------------------
// pctc_in_if: input byte channel
// Valid/ready channel carrying one input word.
// ----------------------------------------------------------------------------
interface pctc_in_if;
  import pctc_pkg::*;

  logic     valid;
  logic     ready;
  in_word_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

FILE: hdl/pctc_out_if.sv
// ----------------------------------------------------------------------------
// pctc_out_if: result byte channel
// Valid/ready channel carrying one result word.
// ----------------------------------------------------------------------------
interface pctc_out_if;
  import pctc_pkg::*;

  logic      valid;
  logic      ready;
  out_word_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

FILE: hdl/pctc_xlate.sv
// ----------------------------------------------------------------------------
// pctc_xlate: byte translation logic
// Maps one input word and the decoder state to up to three result words
// and the next decoder state.
// ----------------------------------------------------------------------------
module pctc_xlate (
  input  pctc_pkg::in_word_t                    in_word_i,
  input  logic [1:0]                            mode_i,
  input  logic [127:0]                          mask_i,
  input  pctc_pkg::dec_state_t                  st_i,
  output pctc_pkg::dec_state_t                  st_o,
  output logic [1:0]                            res_cnt_o,
  output pctc_pkg::out_word_t [pctc_pkg::MaxRes-1:0] res_o
);
  import pctc_pkg::*;

  always_comb begin
    logic [7:0] c;
    logic [4:0] hv_c;
    logic [4:0] hv_f;
    logic [7:0] dec;
    logic [1:0] n;

    c    = in_word_i.in_byte;
    hv_c = hex_val(c);
    hv_f = hex_val(st_i.first_hex);
    dec  = {hv_f[3:0], hv_c[3:0]};
    n    = 2'd0;
    st_o = st_i;
    res_o = '0;

    if (mode_i == MODE_ENC) begin
      st_o.phase = PH_IDLE;
      if (c <= CH_SPACE || c >= CH_DEL || mask_i[c[6:0]]) begin
        res_o[0] = '{out_byte: CH_PCT, has_byte: 1'b1, default: 1'b0};
        res_o[1] = '{out_byte: hex_digit(c[7:4]), has_byte: 1'b1, default: 1'b0};
        res_o[2] = '{out_byte: hex_digit(c[3:0]), has_byte: 1'b1, default: 1'b0};
        n = 2'd3;
      end else begin
        res_o[0] = '{out_byte: c, has_byte: 1'b1, default: 1'b0};
        n = 2'd1;
      end
    end else if (st_i.phase == PH_IDLE) begin
      if (c <= CH_SPACE || c >= CH_DEL) begin
        st_o.err = 1'b1;
        res_o[0] = '{out_byte: c, has_byte: 1'b1, default: 1'b0};
        n = 2'd1;
      end else if (c == CH_PCT) begin
        st_o.phase = PH_PCT;
      end else begin
        res_o[0] = '{out_byte: c, has_byte: 1'b1, default: 1'b0};
        n = 2'd1;
      end
    end else if (!hv_c[4]) begin
      st_o.err   = 1'b1;
      st_o.phase = PH_IDLE;
    end else if (st_i.phase == PH_PCT) begin
      st_o.first_hex = c;
      st_o.phase     = PH_HEX1;
    end else begin
      st_o.phase = PH_IDLE;
      if (mode_i[MODE_KEEP_BIT] && (dec <= CH_SPACE || dec >= CH_DEL || is_uri_delim(dec))) begin
        res_o[0] = '{out_byte: CH_PCT, has_byte: 1'b1, default: 1'b0};
        res_o[1] = '{out_byte: st_i.first_hex, has_byte: 1'b1, default: 1'b0};
        res_o[2] = '{out_byte: c, has_byte: 1'b1, default: 1'b0};
        n = 2'd3;
      end else begin
        res_o[0] = '{out_byte: dec, has_byte: 1'b1, default: 1'b0};
        n = 2'd1;
      end
    end

    if (in_word_i.final_byte) begin
      if (st_o.phase != PH_IDLE) begin
        st_o.err = 1'b1;
      end
      if (n == 2'd0) begin
        res_o[0] = '0;
        n = 2'd1;
      end
      case (n)
        2'd2: begin
          res_o[1].end_of_string = 1'b1;
          res_o[1].bad_input     = st_o.err;
        end
        2'd3: begin
          res_o[2].end_of_string = 1'b1;
          res_o[2].bad_input     = st_o.err;
        end
        default: begin
          res_o[0].end_of_string = 1'b1;
          res_o[0].bad_input     = st_o.err;
        end
      endcase
      st_o = '{phase: PH_IDLE, first_hex: 8'd0, err: 1'b0};
    end

    res_cnt_o = n;
  end

endmodule

FILE: hdl/percent_codec_unit.sv
// ----------------------------------------------------------------------------
// percent_codec_unit: streaming URL percent encoder / decoder
//
//   channel   dir  handshake      word
//   in_i      in   valid/ready    in_byte, final_byte
//   out_o     out  valid/ready    out_byte, has_byte, end_of_string, bad_input
//   cfg       in   cfg_we_i       cfg_idx_i, cfg_data_i
//
// The first result word is presented in the cycle after input acceptance;
// each accepted byte yields zero to three result words, sent one per cycle
// while out_o is ready. A byte giving one word sustains one byte per cycle;
// an expanded escape holds off input while the three-slot result buffer
// drains. Output stalls hold the buffer and block input once it is busy.
// Reset clears the decoder state and the buffer; mode resets to decode.
// ----------------------------------------------------------------------------
module percent_codec_unit (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [pctc_pkg::CfgIdxW-1:0]    cfg_idx_i,
  input  logic [pctc_pkg::CfgDataW-1:0]   cfg_data_i,
  pctc_in_if.sink                         in_i,
  pctc_out_if.source                      out_o
);
  import pctc_pkg::*;

  logic [1:0]          mode_q;
  logic [127:0]        mask_q;
  dec_state_t          st_q, st_d;
  logic [1:0]          cnt_q, cnt_d;
  out_word_t [MaxRes-1:0] slot_q, slot_d;
  out_word_t [MaxRes-1:0] res;
  logic [1:0]          res_cnt;
  logic                accept;
  logic                pop;

  pctc_xlate u_xlate (
    .in_word_i (in_i.data),
    .mode_i    (mode_q),
    .mask_i    (mask_q),
    .st_i      (st_q),
    .st_o      (st_d),
    .res_cnt_o (res_cnt),
    .res_o     (res)
  );

  assign out_o.valid = (cnt_q != 2'd0);
  assign out_o.data  = slot_q[0];
  assign pop         = out_o.valid && out_o.ready;
  assign in_i.ready  = (cnt_q == 2'd0) || (cnt_q == 2'd1 && pop);
  assign accept      = in_i.valid && in_i.ready;

  always_comb begin
    cnt_d  = cnt_q;
    slot_d = slot_q;
    if (accept) begin
      cnt_d  = res_cnt;
      slot_d = res;
    end else if (pop) begin
      cnt_d     = cnt_q - 2'd1;
      slot_d[0] = slot_q[1];
      slot_d[1] = slot_q[2];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= 2'd0;
      st_q  <= '{phase: PH_IDLE, first_hex: 8'd0, err: 1'b0};
    end else begin
      cnt_q <= cnt_d;
      if (accept) begin
        st_q <= st_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    slot_q <= slot_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= MODE_DEC;
      mask_q <= '0;
    end else if (cfg_we_i) begin
      if (cfg_idx_i == REG_MODE) begin
        mode_q <= cfg_data_i[1:0];
      end
      if (cfg_idx_i == REG_MASK_LO) begin
        mask_q[63:0] <= cfg_data_i;
      end
      if (cfg_idx_i == REG_MASK_HI) begin
        mask_q[127:64] <= cfg_data_i;
      end
    end
  end

`ifndef SYNTHESIS
  a_stall_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid && !out_o.ready |=> cnt_q == $past(cnt_q))
    else $error("result buffer changed during output stall");

  a_end_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && in_i.data.final_byte |=> st_q.phase == PH_IDLE && !st_q.err)
    else $error("decoder state not cleared at end of string");

  a_encode_no_err: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && mode_q == MODE_ENC && !st_q.err |=> !st_q.err)
    else $error("encode set the error flag");

  a_bad_on_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid && out_o.data.bad_input |-> out_o.data.end_of_string)
    else $error("bad_input on a word that is not the last");
`endif

endmodule
